// ===== rtl/core/fwfb_pkg.sv =====
// Package for the flow warp frame blend block: payload types, command and
// register codes, fixed constants of the flow encoding. No dependencies.
package fwfb_pkg;

	typedef logic [1:0]  cmd_t;
	typedef logic [7:0]  coord_t;
	typedef logic [23:0] pixel_t;
	typedef logic [7:0]  chan_t;

	localparam cmd_t CMD_LOAD_LEFT  = 2'd0;
	localparam cmd_t CMD_LOAD_RIGHT = 2'd1;
	localparam cmd_t CMD_RENDER     = 2'd2;

	localparam int          CFG_IDX_W       = 2;
	localparam int          CFG_DATA_W      = 17;
	localparam logic [1:0]  REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0]  REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0]  REG_BLEND_POS    = 2'd2;

	localparam logic [8:0]  SIZE_RESET     = 9'd256;
	localparam logic [16:0] POS_ONE        = 17'd65536;
	// half of 255 * 2^16, rounding term of the flow offset
	localparam logic [22:0] FLOW_HALF_DEN  = 23'd8355840;
	localparam int          FLOW_DEN_SHIFT = 16;

endpackage

// ===== rtl/core/fwfb_req_if.sv =====
// Request channel of the flow warp frame blend block: valid/ready plus the
// load or render payload. Depends on fwfb_pkg.
interface fwfb_req_if import fwfb_pkg::*; ();
	logic   valid;
	logic   ready;
	cmd_t   command;
	coord_t pixel_x;
	coord_t pixel_y;
	pixel_t pixel_value;
	pixel_t forward_flow;
	pixel_t backward_flow;

	modport source (
		output valid, command, pixel_x, pixel_y, pixel_value, forward_flow, backward_flow,
		input  ready
	);
	modport sink (
		input  valid, command, pixel_x, pixel_y, pixel_value, forward_flow, backward_flow,
		output ready
	);
endinterface

// ===== rtl/core/fwfb_rsp_if.sv =====
// Result channel of the flow warp frame blend block: valid/ready plus one
// RGB pixel. Depends on fwfb_pkg.
interface fwfb_rsp_if import fwfb_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t out_red;
	chan_t out_green;
	chan_t out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink   (input  valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== rtl/core/flow_warp_frame_blend.sv =====
// Flow warp frame blend: eleven-stage pipeline synthesizing interpolated frame pixels.
// Depends on fwfb_pkg, fwfb_req_if and fwfb_rsp_if.
//
// Load requests write one pixel of the left or right image; render requests
// warp both images by the scaled forward and backward flow, sample each
// bilinearly and cross-fade them by blend_position. One request enters per
// cycle while req.ready is high; a result-side stall can hold it low. Each
// image lives in four memory banks split by column and row parity, so the
// four bilinear neighbors are read in the same cycle at stage seven, where
// loads also write, which keeps reads and writes in request order. Stalls on
// the result side only hold stages that are occupied; bubbles still accept.
// No clearing pass: image words are undefined until loaded. Configuration
// must be written only while the pipeline is empty; the block does not enforce it.
module flow_warp_frame_blend
	import fwfb_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fwfb_req_if.sink              req,
	fwfb_rsp_if.source            rsp
);

	localparam int F    = FRAC_BITS;
	localparam int XHW  = (MAX_WIDTH > 2) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
	localparam int YHW  = (MAX_HEIGHT > 2) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
	localparam int BAW  = XHW + YHW;
	localparam int BD   = 1 << BAW;
	localparam int MW   = 33;
	localparam int SUMW = MW + F + 1;
	localparam int TW   = F + 17;
	localparam int RW   = TW - 7;
	localparam int QW   = F + 9;
	localparam int PW   = F + 10;
	localparam int CW   = F + 9;
	localparam int WW   = 2 * F + 1;
	localparam int PRW  = WW + 8;
	localparam int SW   = 2 * F + 8;
	localparam int BW   = SW + 17;
	localparam int VSW  = BW + 1;
	localparam int SH   = 16 + 2 * F;
	localparam int NST  = 11;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << TW) / 64'd255);

	// configuration
	logic [8:0]  width_q;
	logic [8:0]  height_q;
	logic [16:0] pos_q;
	logic [8:0]  wm1;
	logic [8:0]  hm1;
	logic [16:0] pos_sat;
	logic [16:0] ipos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
			pos_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[8:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[8:0];
				REG_BLEND_POS:    pos_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == 9'd0)
			wm1 = 9'd0;
		else if (int'(width_q) > MAX_WIDTH)
			wm1 = 9'(MAX_WIDTH - 1);
		else
			wm1 = width_q - 9'd1;
		if (height_q == 9'd0)
			hm1 = 9'd0;
		else if (int'(height_q) > MAX_HEIGHT)
			hm1 = 9'(MAX_HEIGHT - 1);
		else
			hm1 = height_q - 9'd1;
		pos_sat = (pos_q > POS_ONE) ? POS_ONE : pos_q;
		ipos    = POS_ONE - pos_sat;
	end

	// pipeline control
	logic [NST:1] vld_q;
	logic [NST:1] en;

	always_comb begin
		en[NST] = !vld_q[NST] || rsp.ready;
		for (int k = NST - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign req.ready = en[1];

	// stage registers
	cmd_t              cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	coord_t            x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	coord_t            y_s1, y_s2, y_s3, y_s4, y_s5, y_s6;
	pixel_t            val_s1, val_s2, val_s3, val_s4, val_s5, val_s6;
	logic [3:0]        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [15:0]       prod_s1 [4];
	logic [MW-1:0]     m_s2 [4];
	logic [TW-1:0]     t_s3 [4];
	logic [TW-1:0]     t_s4 [4];
	logic [TW+RW-1:0]  p_s4 [4];
	logic [QW-1:0]     q_s5 [4];
	logic [CW-1:0]     c_s6 [4];
	pixel_t            rd_s7 [2][4];
	logic [1:0]        xp0_s7, xp1_s7, yp0_s7, yp1_s7;
	logic [WW-1:0]     w_s7 [2][4];
	logic [PRW-1:0]    pr_s8 [2][4][3];
	logic [SW-1:0]     smp_s9 [2][3];
	logic [BW-1:0]     bl_s10 [2][3];
	chan_t             out_s11 [3];

	// stage one: flow direction magnitude products
	logic [7:0] dir [4];
	logic [7:0] mag [4];
	logic [7:0] ad  [4];

	always_comb begin
		dir[0] = req.forward_flow[23:16];
		dir[1] = req.forward_flow[15:8];
		dir[2] = req.backward_flow[23:16];
		dir[3] = req.backward_flow[15:8];
		mag[0] = req.forward_flow[7:0];
		mag[1] = req.forward_flow[7:0];
		mag[2] = req.backward_flow[7:0];
		mag[3] = req.backward_flow[7:0];
		for (int i = 0; i < 4; i++)
			ad[i] = {dir[i][7] ? dir[i][6:0] : ~dir[i][6:0], 1'b1};
	end

	// stages three to six: round, divide by 255, offset and clamp
	logic [SUMW-1:0] tsum [4];
	logic [QW-1:0]   q0 [4];
	logic [TW-1:0]   rem [4];
	logic [TW-1:0]   rem_fix [4];
	logic [QW-1:0]   qfix [4];
	logic signed [PW-1:0] xs [4];
	logic signed [PW-1:0] pc [4];
	logic [CW-1:0]   hi [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tsum[i] = (SUMW'(m_s2[i]) << F) + SUMW'(FLOW_HALF_DEN);
			q0[i]   = QW'(p_s4[i] >> TW);
			rem[i]  = t_s4[i] - ((TW'(q0[i]) << 8) - TW'(q0[i]));
			if (rem[i] >= TW'(510)) begin
				qfix[i]    = q0[i] + QW'(2);
				rem_fix[i] = rem[i] - TW'(510);
			end else if (rem[i] >= TW'(255)) begin
				qfix[i]    = q0[i] + QW'(1);
				rem_fix[i] = rem[i] - TW'(255);
			end else begin
				qfix[i]    = q0[i];
				rem_fix[i] = rem[i];
			end
			xs[i] = $signed(PW'({(i % 2 == 0) ? x_s5 : y_s5, {F{1'b0}}}));
			hi[i] = CW'({(i % 2 == 0) ? wm1 : hm1, {F{1'b0}}});
			if (neg_s5[i])
				pc[i] = xs[i] + $signed(PW'(q_s5[i]));
			else
				pc[i] = xs[i] - $signed(PW'(q_s5[i]));
		end
	end

	// stage seven: bank addressing and weights
	logic [8:0]     x0 [2];
	logic [8:0]     x1 [2];
	logic [8:0]     y0 [2];
	logic [8:0]     y1 [2];
	logic [F-1:0]   fx [2];
	logic [F-1:0]   fy [2];
	logic [F:0]     ofx [2];
	logic [F:0]     ofy [2];
	logic [BAW-1:0] raddr [2][4];
	logic [8:0]     col [2][4];
	logic [8:0]     row [2][4];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			x0[k]  = c_s6[2*k][CW-1:F];
			y0[k]  = c_s6[2*k+1][CW-1:F];
			fx[k]  = c_s6[2*k][F-1:0];
			fy[k]  = c_s6[2*k+1][F-1:0];
			x1[k]  = x0[k] + 9'(fx[k] != '0);
			y1[k]  = y0[k] + 9'(fy[k] != '0);
			ofx[k] = (F+1)'(1 << F) - (F+1)'(fx[k]);
			ofy[k] = (F+1)'(1 << F) - (F+1)'(fy[k]);
			for (int b = 0; b < 4; b++) begin
				col[k][b]   = (x0[k][0] == b[0]) ? x0[k] : x1[k];
				row[k][b]   = (y0[k][0] == b[1]) ? y0[k] : y1[k];
				raddr[k][b] = {YHW'(row[k][b] >> 1), XHW'(col[k][b] >> 1)};
			end
		end
	end

	// image memories: two images, four parity banks each
	logic           load_ok;
	logic [1:0]     wbank;
	logic [BAW-1:0] waddr;

	assign load_ok = vld_q[6] && en[7]
		&& (cmd_s6 == CMD_LOAD_LEFT || cmd_s6 == CMD_LOAD_RIGHT)
		&& (int'(x_s6) < MAX_WIDTH) && (int'(y_s6) < MAX_HEIGHT);
	assign wbank = {y_s6[0], x_s6[0]};
	assign waddr = {YHW'(y_s6 >> 1), XHW'(x_s6 >> 1)};

	for (genvar gk = 0; gk < 2; gk++) begin : g_img
		for (genvar gb = 0; gb < 4; gb++) begin : g_bank
			pixel_t bank_mem_q [BD];
			always_ff @(posedge clk) begin
				if (load_ok && wbank == 2'(gb) && (cmd_s6 == (gk == 0 ? CMD_LOAD_LEFT
					: CMD_LOAD_RIGHT)))
					bank_mem_q[waddr] <= val_s6;
				if (en[7])
					rd_s7[gk][gb] <= bank_mem_q[raddr[gk][gb]];
			end
		end
	end

	// stage eight: neighbor select
	pixel_t nb [2][4];

	always_comb begin
		for (int k = 0; k < 2; k++)
			for (int n = 0; n < 4; n++)
				nb[k][n] = rd_s7[k][{n[1] ? yp1_s7[k] : yp0_s7[k],
					n[0] ? xp1_s7[k] : xp0_s7[k]}];
	end

	// stage eleven: blend, round, saturate
	logic [VSW-1:0] vsum [3];
	logic [8:0]     vres [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vsum[c] = (VSW'(bl_s10[0][c]) + VSW'(bl_s10[1][c]) + (VSW'(1) << (SH - 1))) >> SH;
			vres[c] = vsum[c][8:0];
		end
	end

	// payload datapath
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s1 <= req.command;
			x_s1   <= req.pixel_x;
			y_s1   <= req.pixel_y;
			val_s1 <= req.pixel_value;
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= 16'(mag[i]) * 16'(ad[i]);
				neg_s1[i]  <= !dir[i][7];
			end
		end
		if (en[2]) begin
			cmd_s2 <= cmd_s1; x_s2 <= x_s1; y_s2 <= y_s1; val_s2 <= val_s1;
			neg_s2 <= neg_s1;
			for (int i = 0; i < 4; i++)
				m_s2[i] <= MW'(i < 2 ? pos_sat : ipos) * MW'(prod_s1[i]);
		end
		if (en[3]) begin
			cmd_s3 <= cmd_s2; x_s3 <= x_s2; y_s3 <= y_s2; val_s3 <= val_s2;
			neg_s3 <= neg_s2;
			for (int i = 0; i < 4; i++)
				t_s3[i] <= TW'(tsum[i] >> FLOW_DEN_SHIFT);
		end
		if (en[4]) begin
			cmd_s4 <= cmd_s3; x_s4 <= x_s3; y_s4 <= y_s3; val_s4 <= val_s3;
			neg_s4 <= neg_s3;
			for (int i = 0; i < 4; i++) begin
				t_s4[i] <= t_s3[i];
				p_s4[i] <= (TW+RW)'(t_s3[i]) * (TW+RW)'(RECIP);
			end
		end
		if (en[5]) begin
			cmd_s5 <= cmd_s4; x_s5 <= x_s4; y_s5 <= y_s4; val_s5 <= val_s4;
			neg_s5 <= neg_s4;
			for (int i = 0; i < 4; i++)
				q_s5[i] <= qfix[i];
		end
		if (en[6]) begin
			cmd_s6 <= cmd_s5; x_s6 <= x_s5; y_s6 <= y_s5; val_s6 <= val_s5;
			for (int i = 0; i < 4; i++) begin
				if (pc[i] < 0)
					c_s6[i] <= '0;
				else if (pc[i] > $signed(PW'(hi[i])))
					c_s6[i] <= hi[i];
				else
					c_s6[i] <= CW'(pc[i]);
			end
		end
		if (en[7]) begin
			for (int k = 0; k < 2; k++) begin
				xp0_s7[k] <= x0[k][0];
				xp1_s7[k] <= x1[k][0];
				yp0_s7[k] <= y0[k][0];
				yp1_s7[k] <= y1[k][0];
				w_s7[k][0] <= WW'(ofx[k]) * WW'(ofy[k]);
				w_s7[k][1] <= WW'(fx[k]) * WW'(ofy[k]);
				w_s7[k][2] <= WW'(ofx[k]) * WW'(fy[k]);
				w_s7[k][3] <= WW'(fx[k]) * WW'(fy[k]);
			end
		end
		if (en[8]) begin
			for (int k = 0; k < 2; k++)
				for (int n = 0; n < 4; n++)
					for (int c = 0; c < 3; c++)
						pr_s8[k][n][c] <= PRW'(w_s7[k][n])
							* PRW'(nb[k][n][23 - 8*c -: 8]);
		end
		if (en[9]) begin
			for (int k = 0; k < 2; k++)
				for (int c = 0; c < 3; c++)
					smp_s9[k][c] <= SW'(pr_s8[k][0][c] + pr_s8[k][1][c]
						+ pr_s8[k][2][c] + pr_s8[k][3][c]);
		end
		if (en[10]) begin
			for (int c = 0; c < 3; c++) begin
				bl_s10[0][c] <= BW'(ipos) * BW'(smp_s9[0][c]);
				bl_s10[1][c] <= BW'(pos_sat) * BW'(smp_s9[1][c]);
			end
		end
		if (en[11]) begin
			for (int c = 0; c < 3; c++)
				out_s11[c] <= vres[c][8] ? 8'hFF : vres[c][7:0];
		end
	end

	// valid chain; only renders continue past the memory stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NST; k++) begin
				if (en[k]) begin
					if (k == 1)
						vld_q[k] <= req.valid;
					else if (k == 7)
						vld_q[k] <= vld_q[6] && (cmd_s6 == CMD_RENDER);
					else
						vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign rsp.valid     = vld_q[NST];
	assign rsp.out_red   = out_s11[0];
	assign rsp.out_green = out_s11[1];
	assign rsp.out_blue  = out_s11[2];

	// checks
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] |-> (rem_fix[0] < TW'(255)) && (rem_fix[1] < TW'(255))
			&& (rem_fix[2] < TW'(255)) && (rem_fix[3] < TW'(255)))
		else $error("flow offset division remainder out of range");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[6] |-> (c_s6[0] <= CW'({wm1, {F{1'b0}}}))
			&& (c_s6[1] <= CW'({hm1, {F{1'b0}}})))
		else $error("left sample position outside image");

	a_weights: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[7] |-> (32'(w_s7[0][0]) + 32'(w_s7[0][1]) + 32'(w_s7[0][2])
			+ 32'(w_s7[0][3])) == (32'(1) << (2 * F)))
		else $error("bilinear weights do not sum to one");

endmodule

// ===== tb/tb.sv =====
// Testbench for flow_warp_frame_blend: loads both images, renders pixels under several
// image sizes and blend positions, and checks each result against a scoreboard predictor.
// Depends on fwfb_pkg, fwfb_req_if, fwfb_rsp_if and the block itself.
class blend_scoreboard;
	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic [23:0] left_mem [65536];
	logic [23:0] right_mem [65536];
	int unsigned width_reg;
	int unsigned height_reg;
	int unsigned pos_reg;
	rgb_t pending_pixels [$];
	int errors;

	function new();
		width_reg = 256;
		height_reg = 256;
		pos_reg = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [16:0] val);
		if (idx == fwfb_pkg::REG_IMAGE_WIDTH) width_reg = 32'(val[8:0]);
		else if (idx == fwfb_pkg::REG_IMAGE_HEIGHT) height_reg = 32'(val[8:0]);
		else if (idx == fwfb_pkg::REG_BLEND_POS) pos_reg = 32'(val);
	endfunction

	function longint flow_shift(longint unsigned pos, longint unsigned mag,
			longint unsigned dir);
		longint d;
		longint unsigned ad;
		longint unsigned m;
		longint unsigned q;
		d = 2 * longint'(dir) - 255;
		ad = (d < 0) ? -d : d;
		m = pos * mag * ad;
		q = ((m << 8) + 64'd8355840) / 64'd16711680;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function longint clamp_coord(longint v, int unsigned size);
		longint hi;
		hi = longint'(size - 1) << 8;
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function void bilinear(bit use_right, longint px, longint py, output longint unsigned acc [3]);
		int unsigned x0, y0, x1, y1;
		longint unsigned fx, fy;
		logic [23:0] p [4];
		longint unsigned w [4];
		x0 = 32'(px >> 8);
		y0 = 32'(py >> 8);
		fx = 64'(px & 255);
		fy = 64'(py & 255);
		x1 = (fx != 0) ? x0 + 1 : x0;
		y1 = (fy != 0) ? y0 + 1 : y0;
		if (use_right) begin
			p[0] = right_mem[(y0 * 256 + x0) % 65536];
			p[1] = right_mem[(y0 * 256 + x1) % 65536];
			p[2] = right_mem[(y1 * 256 + x0) % 65536];
			p[3] = right_mem[(y1 * 256 + x1) % 65536];
		end else begin
			p[0] = left_mem[(y0 * 256 + x0) % 65536];
			p[1] = left_mem[(y0 * 256 + x1) % 65536];
			p[2] = left_mem[(y1 * 256 + x0) % 65536];
			p[3] = left_mem[(y1 * 256 + x1) % 65536];
		end
		w[0] = (256 - fx) * (256 - fy);
		w[1] = fx * (256 - fy);
		w[2] = (256 - fx) * fy;
		w[3] = fx * fy;
		for (int c = 0; c < 3; c++) begin
			acc[c] = 0;
			for (int k = 0; k < 4; k++)
				acc[c] += w[k] * ((p[k] >> (16 - 8 * c)) & 255);
		end
	endfunction

	function rgb_t predict_pixel(logic [7:0] x, logic [7:0] y, logic [23:0] ff,
			logic [23:0] bf);
		int unsigned w, h, pos, ipos;
		longint px, py;
		longint unsigned ls [3];
		longint unsigned rs [3];
		longint unsigned v;
		logic [7:0] ch [3];
		rgb_t res;
		w = (width_reg < 1) ? 1 : ((width_reg > 256) ? 256 : width_reg);
		h = (height_reg < 1) ? 1 : ((height_reg > 256) ? 256 : height_reg);
		pos = (pos_reg > 65536) ? 65536 : pos_reg;
		ipos = 65536 - pos;
		px = (longint'(x) << 8) - flow_shift(pos, ff[7:0], ff[23:16]);
		py = (longint'(y) << 8) - flow_shift(pos, ff[7:0], ff[15:8]);
		bilinear(0, clamp_coord(px, w), clamp_coord(py, h), ls);
		px = (longint'(x) << 8) - flow_shift(ipos, bf[7:0], bf[23:16]);
		py = (longint'(y) << 8) - flow_shift(ipos, bf[7:0], bf[15:8]);
		bilinear(1, clamp_coord(px, w), clamp_coord(py, h), rs);
		for (int c = 0; c < 3; c++) begin
			v = longint'(ipos) * ls[c] + longint'(pos) * rs[c];
			v = (v + (64'd1 << 31)) >> 32;
			ch[c] = (v > 255) ? 8'd255 : v[7:0];
		end
		res.r = ch[0];
		res.g = ch[1];
		res.b = ch[2];
		return res;
	endfunction

	function void note_request(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
			logic [23:0] val, logic [23:0] ff, logic [23:0] bf);
		if (cmd == fwfb_pkg::CMD_LOAD_LEFT) left_mem[{y, x}] = val;
		else if (cmd == fwfb_pkg::CMD_LOAD_RIGHT) right_mem[{y, x}] = val;
		else if (cmd == fwfb_pkg::CMD_RENDER) pending_pixels.push_back(predict_pixel(x, y, ff, bf));
	endfunction

	function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		rgb_t e;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected pixel %h %h %h", $realtime, r, g, b);
			errors++;
			return;
		end
		e = pending_pixels.pop_front();
		if (r !== e.r || g !== e.g || b !== e.b) begin
			$display("%0t: pixel mismatch expected %h %h %h actual %h %h %h",
				$realtime, e.r, e.g, e.b, r, g, b);
			errors++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fwfb_pkg::*;

	localparam cmd_t CMD_IDLE = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fwfb_req_if req_ch ();
	fwfb_rsp_if rsp_ch ();

	flow_warp_frame_blend dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	blend_scoreboard sb;
	bit left_loaded [65536];
	bit right_loaded [65536];
	int burst_left;
	int stall_mode;
	int stall_left;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(1, 40);
		end
		stall_left--;
		case (stall_mode)
			0: rsp_ch.ready = 1'b1;
			1: rsp_ch.ready = 1'($urandom_range(0, 1));
			2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready = (stall_left % 7) < 4;
		endcase
	end

	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_pixel(rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue);

	task automatic send(cmd_t cmd, coord_t x, coord_t y, pixel_t val, pixel_t ff, pixel_t bf);
		if (burst_left == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		req_ch.valid = 1'b1;
		req_ch.command = cmd;
		req_ch.pixel_x = x;
		req_ch.pixel_y = y;
		req_ch.pixel_value = val;
		req_ch.forward_flow = ff;
		req_ch.backward_flow = bf;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(cmd, x, y, val, ff, bf);
		if (cmd == CMD_LOAD_LEFT) left_loaded[{y, x}] = 1;
		if (cmd == CMD_LOAD_RIGHT) right_loaded[{y, x}] = 1;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		req_ch.valid = 1'b0;
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic drain();
		int guard;
		req_ch.valid = 1'b0;
		guard = 0;
		while (sb.pending_pixels.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (30) @(negedge clk);
	endtask

	function automatic int fit_size(int v);
		return (v < 1) ? 1 : ((v > 256) ? 256 : v);
	endfunction

	task automatic setup_phase(int w, int h, int pos);
		int sw, sh;
		drain();
		write_reg(REG_IMAGE_WIDTH, 17'(w));
		write_reg(REG_IMAGE_HEIGHT, 17'(h));
		write_reg(REG_BLEND_POS, 17'(pos));
		sw = fit_size(w);
		sh = fit_size(h);
		for (int y = 0; y < sh; y++)
			for (int x = 0; x < sw; x++) begin
				if (!left_loaded[y * 256 + x])
					send(CMD_LOAD_LEFT, coord_t'(x), coord_t'(y), pixel_t'($urandom),
						pixel_t'($urandom), pixel_t'($urandom));
				if (!right_loaded[y * 256 + x])
					send(CMD_LOAD_RIGHT, coord_t'(x), coord_t'(y), pixel_t'($urandom),
						pixel_t'($urandom), pixel_t'($urandom));
			end
	endtask

	function automatic pixel_t rand_flow();
		pixel_t f;
		f = pixel_t'($urandom);
		case ($urandom_range(0, 5))
			0: f[7:0] = 8'd0;
			1: f[7:0] = 8'd255;
			2: f[23:16] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
			default: ;
		endcase
		return f;
	endfunction

	task automatic random_phase(int w, int h, int pos, int renders);
		int sw, sh, k;
		coord_t x, y;
		setup_phase(w, h, pos);
		sw = fit_size(w);
		sh = fit_size(h);
		for (int i = 0; i < renders; i++) begin
			k = $urandom_range(0, 19);
			if ($urandom_range(0, 1)) begin
				x = coord_t'($urandom_range(0, (sw + 2 > 255) ? 255 : sw + 2));
				y = coord_t'($urandom_range(0, (sh + 2 > 255) ? 255 : sh + 2));
			end else begin
				x = coord_t'($urandom);
				y = coord_t'($urandom);
			end
			if (k == 0)
				send(CMD_IDLE, coord_t'($urandom), coord_t'($urandom), pixel_t'($urandom),
					pixel_t'($urandom), pixel_t'($urandom));
			else if (k < 3)
				send($urandom_range(0, 1) ? CMD_LOAD_RIGHT : CMD_LOAD_LEFT,
					coord_t'($urandom_range(0, sw - 1)), coord_t'($urandom_range(0, sh - 1)),
					pixel_t'($urandom), pixel_t'($urandom), pixel_t'($urandom));
			else
				send(CMD_RENDER, x, y, pixel_t'($urandom), rand_flow(), rand_flow());
		end
	endtask

	initial begin
		int w, h, pos;
		sb = new();
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_IDLE;
		req_ch.pixel_x = '0;
		req_ch.pixel_y = '0;
		req_ch.pixel_value = '0;
		req_ch.forward_flow = '0;
		req_ch.backward_flow = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		setup_phase(4, 3, 32768);
		send(CMD_RENDER, 8'd0, 8'd0, 24'h000000, 24'h000000, 24'h000000);
		send(CMD_RENDER, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send(CMD_RENDER, 8'd1, 8'd1, 24'h0000FF, 24'h0000FF, 24'hFFFFFF);
		send(CMD_RENDER, 8'd2, 8'd1, 24'h0, 24'hFF00FF, 24'h00FFFF);
		send(CMD_RENDER, 8'd3, 8'd2, 24'h0, 24'h808001, 24'h7F7FFF);
		send(CMD_RENDER, 8'd200, 8'd0, 24'h0, 24'h000000, 24'hFF0080);
		send(CMD_RENDER, 8'd0, 8'd255, 24'h0, 24'hFFFFFF, 24'h000000);
		send(CMD_IDLE, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send(CMD_LOAD_LEFT, 8'd3, 8'd2, 24'hFFFFFF, 24'h0, 24'h0);
		send(CMD_LOAD_RIGHT, 8'd3, 8'd2, 24'hFFFFFF, 24'h0, 24'h0);
		send(CMD_RENDER, 8'd3, 8'd2, 24'h0, 24'h0, 24'h0);
		send(CMD_LOAD_LEFT, 8'd0, 8'd0, 24'h000000, 24'h0, 24'h0);
		send(CMD_RENDER, 8'd0, 8'd0, 24'h0, 24'hFFFFFF, 24'h0000FF);

		random_phase(1, 1, 0, 20);
		random_phase(0, 0, 65536, 20);
		random_phase(17, 9, 131071, 40);
		random_phase(2, 5, 1, 40);
		for (int p = 0; p < 16; p++) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
			if ($urandom_range(0, 7) == 0) begin
				w = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
				h = 1;
			end
			pos = $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
			random_phase(w, h, pos, 45);
		end
		random_phase(256, 1, $urandom_range(0, 65536), 60);
		random_phase(511, 1, 65535, 60);

		drain();
		if (sb.errors == 0 && sb.pending_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/fwfb_pkg.sv
rtl/core/fwfb_req_if.sv
rtl/core/fwfb_rsp_if.sv
rtl/core/flow_warp_frame_blend.sv
tb/tb.sv
